@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the activation unit modules; clocked on clk,
// disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EAU_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EAU_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/eau_pkg.sv @@
// ----------------------------------------------------------------------------
// eau_pkg
// Opcodes, shared types and the sigmoid sample generator of the activation
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eau_pkg;

  localparam int DEF_FRAC_BITS      = 12;
  localparam int DEF_TABLE_SEGMENTS = 64;
  localparam int VALUE_W            = 16;
  localparam int OPCODE_W           = 3;
  localparam int ALPHA_W            = 12;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 12'd41;
  localparam int SERIES_TERMS       = 20;

  typedef enum logic [OPCODE_W-1:0] {
    OP_RELU      = 3'd0,
    OP_LEAKY     = 3'd1,
    OP_SIGMOID   = 3'd2,
    OP_TANH      = 3'd3,
    OP_SWISH     = 3'd4,
    OP_RELU_D    = 3'd5,
    OP_SIGMOID_D = 3'd6,
    OP_TANH_D    = 3'd7
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] x;
    logic                      neg;
  } item_ctrl_t;

  // restoring long division, elaboration only
  function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] rem;
    logic [127:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 127; b >= 0; b--) begin
      rem = {rem[126:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sample idx of 1/(1+e^-t), t = idx*8/segs, with frac fraction bits
  function automatic logic [31:0] sig_entry(input int frac, input int segs, input int idx);
    logic [127:0] h;
    logic [127:0] term;
    logic [127:0] q;
    logic [127:0] e;
    logic [127:0] d;
    logic [127:0] num;
    h    = udiv(128'd1 << 35, 128'(segs));
    term = 128'd1 << 32;
    q    = term;
    e    = term;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = udiv((term * h) >> 32, 128'(k));
      if (k[0]) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (int j = 0; j < idx; j++) begin
      e = (e * q + (128'd1 << 31)) >> 32;
    end
    d   = (128'd1 << 32) + e;
    num = (128'd1 << (frac + 32)) + (d >> 1);
    return 32'(udiv(num, d));
  endfunction

endpackage

`default_nettype wire

@@ sv/elementwise_activation_unit_top.sv @@
// ----------------------------------------------------------------------------
// elementwise_activation_unit_top
// Element-wise activation unit: relu, leaky relu, sigmoid, tanh, swish and
// the relu, sigmoid and tanh derivatives on signed fixed-point elements.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------
//   input    | in_valid/in_ready  | opcode, value
//   output   | out_valid/out_ready| result
//   config   | cfg_we             | cfg_wdata (leaky slope)
//
// One transaction per cycle while the output is not stalled; five register
// stages (argument, table read, interpolation, multiply, round/saturate).
// The table is constant logic, so no clearing pass follows reset.
// rst clears all stage valid bits and sets the leaky slope to its default.
// A stall on the output fills empty stages first; in_ready falls only when
// every stage holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module elementwise_activation_unit_top #(
  parameter int FRAC_BITS      = eau_pkg::DEF_FRAC_BITS,
  parameter int TABLE_SEGMENTS = eau_pkg::DEF_TABLE_SEGMENTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [eau_pkg::OPCODE_W-1:0]       opcode,
  input  logic signed [eau_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [eau_pkg::VALUE_W-1:0] result,
  input  logic                               cfg_we,
  input  logic [eau_pkg::ALPHA_W-1:0]        cfg_wdata
);

  logic [eau_pkg::ALPHA_W-1:0] leaky_alpha;
  logic                        a_valid;
  logic                        a_ready;
  logic [FRAC_BITS+3:0]        a_mag;
  eau_pkg::item_ctrl_t         a_ctrl;
  logic                        s_valid;
  logic                        s_ready;
  logic [FRAC_BITS:0]          s_sig;
  eau_pkg::item_ctrl_t         s_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaky_alpha <= eau_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      leaky_alpha <= cfg_wdata;
    end
  end

  eau_arg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_arg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .value    (value),
    .out_valid(a_valid),
    .out_ready(a_ready),
    .mag      (a_mag),
    .ctrl     (a_ctrl)
  );

  eau_sig_lut #(
    .FRAC_BITS     (FRAC_BITS),
    .TABLE_SEGMENTS(TABLE_SEGMENTS)
  ) u_sig_lut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_valid),
    .in_ready (a_ready),
    .mag      (a_mag),
    .ctrl_in  (a_ctrl),
    .out_valid(s_valid),
    .out_ready(s_ready),
    .sig_abs  (s_sig),
    .ctrl_out (s_ctrl)
  );

  eau_post #(
    .FRAC_BITS(FRAC_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .in_ready (s_ready),
    .sig_abs  (s_sig),
    .ctrl_in  (s_ctrl),
    .alpha    (leaky_alpha),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result   (result)
  );

  `EAU_ASSERT_IMPL(a_full_before_stall, !in_ready, out_valid && !out_ready && a_valid && s_valid, "input held off with a free stage")

endmodule

`default_nettype wire

@@ sv/eau_arg.sv @@
// ----------------------------------------------------------------------------
// eau_arg
// Input stage: picks the sigmoid argument (x, or 2x for tanh and its
// derivative), takes its magnitude and clamps it to the table span.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module eau_arg #(
  parameter int FRAC_BITS = eau_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [eau_pkg::OPCODE_W-1:0]        opcode,
  input  logic signed [eau_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [FRAC_BITS+3:0]                mag,
  output eau_pkg::item_ctrl_t                 ctrl
);

  localparam int AW = FRAC_BITS + 4;
  localparam int CW = (AW > 17) ? AW : 17;
  localparam logic [CW-1:0] SPAN = CW'(64'd8 << FRAC_BITS);

  eau_pkg::op_t        op_in;
  logic signed [17:0]  arg;
  logic [16:0]         arg_abs;
  logic [CW-1:0]       arg_w;
  logic [AW-1:0]       mag_next;
  eau_pkg::item_ctrl_t ctrl_next;
  logic                v1;

  assign op_in = eau_pkg::op_t'(opcode);

  always_comb begin
    if (op_in == eau_pkg::OP_TANH || op_in == eau_pkg::OP_TANH_D) begin
      arg = {value[15], value, 1'b0};
    end else begin
      arg = {{2{value[15]}}, value};
    end
    arg_abs  = arg[17] ? 17'(-arg) : 17'(arg);
    arg_w    = CW'(arg_abs);
    mag_next = (arg_w > SPAN) ? AW'(SPAN) : AW'(arg_w);
    ctrl_next.op  = op_in;
    ctrl_next.x   = value;
    ctrl_next.neg = arg[17];
  end

  assign in_ready  = !v1 || out_ready;
  assign out_valid = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mag  <= mag_next;
      ctrl <= ctrl_next;
    end
  end

  `EAU_ASSERT_NEXT(a_arg_capture, in_valid && in_ready, out_valid, "accepted transaction not held in input stage")

endmodule

`default_nettype wire

@@ sv/eau_sig_lut.sv @@
// ----------------------------------------------------------------------------
// eau_sig_lut
// Sigmoid of the clamped magnitude: table read of two neighbouring samples,
// then linear interpolation. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module eau_sig_lut #(
  parameter int FRAC_BITS      = eau_pkg::DEF_FRAC_BITS,
  parameter int TABLE_SEGMENTS = eau_pkg::DEF_TABLE_SEGMENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FRAC_BITS+3:0] mag,
  input  eau_pkg::item_ctrl_t ctrl_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FRAC_BITS:0]  sig_abs,
  output eau_pkg::item_ctrl_t ctrl_out
);

  localparam int AW   = FRAC_BITS + 4;
  localparam int IW   = $clog2(TABLE_SEGMENTS + 1);
  localparam int PW   = AW + IW;
  localparam int RW   = FRAC_BITS + 3;
  localparam int SW   = FRAC_BITS + 1;
  localparam int MW   = SW + RW + 1;
  localparam int TN   = TABLE_SEGMENTS + 1;
  localparam logic [PW-1:0] SEGS  = PW'(TABLE_SEGMENTS);
  localparam logic [IW-1:0] LAST  = IW'(TABLE_SEGMENTS);
  localparam logic [MW-1:0] HALF  = MW'(1) << (RW - 1);
  localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  logic [SW-1:0] lut [TN];

  for (genvar gi = 0; gi < TN; gi++) begin : g_lut
    localparam logic [31:0] ENTRY = eau_pkg::sig_entry(FRAC_BITS, TABLE_SEGMENTS, gi);
    assign lut[gi] = ENTRY[SW-1:0];
  end

  logic [PW-1:0]       p;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       idx_hi;
  logic                last;
  logic [SW-1:0]       delta_next;
  logic                v2;
  logic                v3;
  logic                ready2;
  logic                ready3;
  logic [SW-1:0]       s0;
  logic [SW-1:0]       delta;
  logic [RW-1:0]       r;
  eau_pkg::item_ctrl_t ctrl2;
  logic [MW-1:0]       ip;
  logic [SW-1:0]       sig_next;

  always_comb begin
    p          = PW'(mag) * SEGS;
    idx        = IW'(p >> RW);
    last       = (idx == LAST);
    idx_hi     = last ? idx : idx + IW'(1);
    delta_next = last ? '0 : lut[idx_hi] - lut[idx];
  end

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign in_ready = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready2) begin
        v2 <= in_valid;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && in_valid) begin
      s0    <= lut[idx];
      delta <= delta_next;
      r     <= p[RW-1:0];
      ctrl2 <= ctrl_in;
    end
  end

  always_comb begin
    ip       = MW'(delta) * MW'(r) + HALF;
    sig_next = s0 + SW'(ip >> RW);
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      sig_abs  <= sig_next;
      ctrl_out <= ctrl2;
    end
  end

  assign out_valid = v3;

  `EAU_ASSERT_IMPL(a_sig_le_one, v3, sig_abs <= ONE_S, "interpolated sigmoid above one")

endmodule

`default_nettype wire

@@ sv/eau_post.sv @@
// ----------------------------------------------------------------------------
// eau_post
// Back end: sigmoid sign fold, tanh, one shared multiplier, rounding, final
// select and saturation. Two register stages, the second is the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module eau_post #(
  parameter int FRAC_BITS = eau_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [FRAC_BITS:0]                 sig_abs,
  input  eau_pkg::item_ctrl_t                ctrl_in,
  input  logic [eau_pkg::ALPHA_W-1:0]        alpha,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [eau_pkg::VALUE_W-1:0] result
);

  localparam int SW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 3;
  localparam int MA = (TW > eau_pkg::VALUE_W) ? TW : eau_pkg::VALUE_W;
  localparam int MB = (TW > eau_pkg::ALPHA_W + 1) ? TW : eau_pkg::ALPHA_W + 1;
  localparam int PW = MA + MB;
  localparam int EW = PW + 1;
  localparam logic [SW-1:0]        ONE_S  = SW'(1) << FRAC_BITS;
  localparam logic signed [TW-1:0] T_MAX  = TW'(ONE_S);
  localparam logic signed [TW-1:0] T_MIN  = -T_MAX;
  localparam logic signed [EW-1:0] ONE_E  = EW'(ONE_S);
  localparam logic signed [EW-1:0] RND_F  = EW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] RND_A  = EW'(1) << (eau_pkg::ALPHA_W - 1);
  localparam logic signed [EW-1:0] SAT_HI = EW'(32767);
  localparam logic signed [EW-1:0] SAT_LO = -EW'(32768);

  logic [SW-1:0]              sig;
  logic [SW-1:0]              om;
  logic signed [TW-1:0]       t;
  logic signed [TW-1:0]       sig_s;
  logic signed [TW-1:0]       om_s;
  logic signed [MA-1:0]       ma;
  logic signed [MB-1:0]       mb;
  logic                       v4;
  logic                       v5;
  logic                       ready4;
  logic                       ready5;
  logic signed [PW-1:0]       prod;
  logic [SW-1:0]              sig4;
  logic signed [TW-1:0]       t4;
  eau_pkg::item_ctrl_t        ctrl4;
  logic signed [EW-1:0]       prod_e;
  logic signed [EW-1:0]       rnd_f;
  logic signed [EW-1:0]       rnd_a;
  logic signed [EW-1:0]       x_e;
  logic                       x_pos;
  logic signed [EW-1:0]       cand;
  logic signed [eau_pkg::VALUE_W-1:0] result_next;

  always_comb begin
    sig   = ctrl_in.neg ? ONE_S - sig_abs : sig_abs;
    om    = ONE_S - sig;
    sig_s = $signed({2'b00, sig});
    om_s  = $signed({2'b00, om});
    t     = $signed({1'b0, sig, 1'b0}) - T_MAX;
    case (ctrl_in.op)
      eau_pkg::OP_LEAKY: begin
        ma = MA'(ctrl_in.x);
        mb = $signed(MB'(alpha));
      end
      eau_pkg::OP_SIGMOID_D: begin
        ma = MA'(sig_s);
        mb = MB'(om_s);
      end
      eau_pkg::OP_TANH_D: begin
        ma = MA'(t);
        mb = MB'(t);
      end
      default: begin
        ma = MA'(ctrl_in.x);
        mb = MB'(sig_s);
      end
    endcase
  end

  assign ready5   = !v5 || out_ready;
  assign ready4   = !v4 || ready5;
  assign in_ready = ready4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ready4) begin
        v4 <= in_valid;
      end
      if (ready5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && in_valid) begin
      prod  <= PW'(ma) * PW'(mb);
      sig4  <= sig;
      t4    <= t;
      ctrl4 <= ctrl_in;
    end
  end

  always_comb begin
    prod_e = EW'(prod);
    rnd_f  = (prod_e + RND_F) >>> FRAC_BITS;
    rnd_a  = (prod_e + RND_A) >>> eau_pkg::ALPHA_W;
    x_e    = EW'(ctrl4.x);
    x_pos  = !ctrl4.x[eau_pkg::VALUE_W-1] && (ctrl4.x != '0);
    case (ctrl4.op)
      eau_pkg::OP_RELU:      cand = x_pos ? x_e : '0;
      eau_pkg::OP_LEAKY:     cand = x_pos ? x_e : rnd_a;
      eau_pkg::OP_SIGMOID:   cand = $signed(EW'(sig4));
      eau_pkg::OP_TANH:      cand = EW'(t4);
      eau_pkg::OP_SWISH:     cand = rnd_f;
      eau_pkg::OP_RELU_D:    cand = x_pos ? ONE_E : '0;
      eau_pkg::OP_SIGMOID_D: cand = rnd_f;
      eau_pkg::OP_TANH_D:    cand = ONE_E - rnd_f;
      default:               cand = '0;
    endcase
    if (cand > SAT_HI) begin
      result_next = 16'sh7fff;
    end else if (cand < SAT_LO) begin
      result_next = 16'sh8000;
    end else begin
      result_next = cand[eau_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4) begin
      result <= result_next;
    end
  end

  assign out_valid = v5;

  `EAU_ASSERT_IMPL(a_tanh_range, v4, (t4 <= T_MAX) && (t4 >= T_MIN), "tanh outside minus one to one")

endmodule

`default_nettype wire

@@ tb/tb_elementwise_activation_unit_top.sv @@
// ----------------------------------------------------------------------------
// tb_elementwise_activation_unit_top
// Self-checking bench for the element-wise activation unit. A short table of
// edge cases runs first, then random transactions across several leaky slope
// settings. Every result is checked in order against the table's known value
// if it has one, else a local fixed-point model of the unit. Both handshakes
// are throttled at random, with one long output stall to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_elementwise_activation_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  import eau_pkg::*;

  localparam int     FRAC      = DEF_FRAC_BITS;
  localparam int     SEGMENTS  = DEF_TABLE_SEGMENTS;
  localparam longint ONE       = longint'(1) << FRAC;
  localparam longint SPAN      = longint'(8) << FRAC;
  localparam int     MAX_GAP   = 12;
  localparam int     HOLD_AT   = 300;
  localparam int     HOLD_LEN  = 60;
  localparam int     SETTLE    = 10;
  localparam int     PHASES    = 5;
  localparam int     PER_PHASE = 215;
  localparam int     N_PROBES  = 25;

  typedef struct packed {
    op_t         op;
    logic [15:0] x;
    logic        known;
    logic [15:0] want;
  } probe_t;

  localparam probe_t PROBES [N_PROBES] = '{
    '{OP_RELU,      16'h0000, 1'b1, 16'h0000},
    '{OP_RELU,      16'h7fff, 1'b1, 16'h7fff},
    '{OP_RELU,      16'h8000, 1'b1, 16'h0000},
    '{OP_RELU,      16'hffff, 1'b1, 16'h0000},
    '{OP_LEAKY,     16'h7fff, 1'b1, 16'h7fff},
    '{OP_LEAKY,     16'h8000, 1'b1, 16'hfeb8},
    '{OP_LEAKY,     16'hffff, 1'b1, 16'h0000},
    '{OP_SIGMOID,   16'h0000, 1'b1, 16'h0800},
    '{OP_SIGMOID,   16'h7fff, 1'b0, 16'h0000},
    '{OP_SIGMOID,   16'h8000, 1'b0, 16'h0000},
    '{OP_SIGMOID,   16'h0e3a, 1'b0, 16'h0000},
    '{OP_TANH,      16'h0000, 1'b1, 16'h0000},
    '{OP_TANH,      16'h4000, 1'b0, 16'h0000},
    '{OP_TANH,      16'h4001, 1'b0, 16'h0000},
    '{OP_TANH,      16'h8000, 1'b0, 16'h0000},
    '{OP_SWISH,     16'h0000, 1'b1, 16'h0000},
    '{OP_SWISH,     16'h7fff, 1'b0, 16'h0000},
    '{OP_SWISH,     16'h8000, 1'b0, 16'h0000},
    '{OP_RELU_D,    16'h0000, 1'b1, 16'h0000},
    '{OP_RELU_D,    16'h0001, 1'b1, 16'h1000},
    '{OP_RELU_D,    16'h8000, 1'b1, 16'h0000},
    '{OP_SIGMOID_D, 16'h0000, 1'b1, 16'h0400},
    '{OP_SIGMOID_D, 16'h7fff, 1'b0, 16'h0000},
    '{OP_TANH_D,    16'h0000, 1'b1, 16'h1000},
    '{OP_TANH_D,    16'h8000, 1'b0, 16'h0000}
  };

  localparam logic [15:0] EDGES [5] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff};

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [OPCODE_W-1:0]       opcode    = '0;
  logic signed [VALUE_W-1:0] value     = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] result;
  logic                      cfg_we    = 1'b0;
  logic [ALPHA_W-1:0]        cfg_wdata = '0;

  logic signed [VALUE_W-1:0] pending_results [$];
  longint                    sig_lut [0:SEGMENTS];
  longint                    leaky_slope;
  int                        mismatches = 0;
  bit                        tx_idle    = 1'b1;
  bit                        rx_idle    = 1'b1;
  bit                        hold_busy  = 1'b0;

  elementwise_activation_unit_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void build_sig_lut();
    longint unsigned step;
    longint unsigned term;
    longint unsigned q;
    longint unsigned e;
    longint unsigned d;
    longint unsigned num;
    step = (64'd1 << 35) / longint'(SEGMENTS);
    term = 64'd1 << 32;
    q    = term;
    e    = term;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * step) >> 32) / longint'(k);
      if (k % 2 == 1) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (int i = 0; i <= SEGMENTS; i++) begin
      d          = (64'd1 << 32) + e;
      num        = (64'd1 << (FRAC + 32)) + (d >> 1);
      sig_lut[i] = longint'(num / d);
      e          = (e * q + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic longint round_q(input longint p, input int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint sigmoid_q(input longint x);
    longint a;
    longint idx;
    longint r;
    longint s;
    a = (x < 0) ? -x : x;
    if (a > SPAN) a = SPAN;
    idx = (a * SEGMENTS) / SPAN;
    r   = (a * SEGMENTS) % SPAN;
    s   = sig_lut[idx];
    if (idx < SEGMENTS) s = s + ((sig_lut[idx + 1] - s) * r + SPAN / 2) / SPAN;
    if (x < 0) s = ONE - s;
    return s;
  endfunction

  function automatic longint tanh_q(input longint x);
    longint t2;
    t2 = 2 * x;
    if (t2 > SPAN) t2 = SPAN;
    if (t2 < -SPAN) t2 = -SPAN;
    return 2 * sigmoid_q(t2) - ONE;
  endfunction

  function automatic logic signed [VALUE_W-1:0] activate(input op_t op,
                                                         input logic signed [VALUE_W-1:0] v);
    longint x;
    longint s;
    longint t;
    longint r;
    x = v;
    case (op)
      OP_RELU:      r = (x > 0) ? x : 0;
      OP_LEAKY:     r = (x > 0) ? x : round_q(x * leaky_slope, ALPHA_W);
      OP_SIGMOID:   r = sigmoid_q(x);
      OP_TANH:      r = tanh_q(x);
      OP_SWISH:     r = round_q(x * sigmoid_q(x), FRAC);
      OP_RELU_D:    r = (x > 0) ? ONE : 0;
      OP_SIGMOID_D: begin
        s = sigmoid_q(x);
        r = round_q(s * (ONE - s), FRAC);
      end
      default: begin
        t = tanh_q(x);
        r = ONE - round_q(t * t, FRAC);
      end
    endcase
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = VALUE_W'($urandom());
      9:          v = EDGES[$urandom_range(0, 4)];
      default: begin
        v = VALUE_W'($urandom_range(0, 16384));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send(input op_t op, input logic [VALUE_W-1:0] x, input logic known,
                      input logic [VALUE_W-1:0] want);
    int gap;
    gap = (tx_idle && !hold_busy) ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= x;
    pending_results.insert(pending_results.size(), known ? want : activate(op, x));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_slope(input logic [ALPHA_W-1:0] a);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_we    <= 1'b0;
    leaky_slope = longint'(a);
  endtask

  initial begin
    logic [ALPHA_W-1:0] slope;
    build_sig_lut();
    leaky_slope = longint'(ALPHA_RESET);
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_PROBES; i++) begin
      send(PROBES[i].op, PROBES[i].x, PROBES[i].known, PROBES[i].want);
    end
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       slope = '0;
        1:       slope = '1;
        4:       slope = ALPHA_RESET;
        default: slope = ALPHA_W'($urandom_range(1, 4094));
      endcase
      set_slope(slope);
      tx_idle = (phase != 2);
      rx_idle = (phase != 2);
      for (int n = 0; n < PER_PHASE; n++) begin
        send(op_t'($urandom_range(0, 7)), draw_value(), 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int                        stall;
    int                        seen;
    logic signed [VALUE_W-1:0] want;
    seen = 0;
    wait (rst == 1'b0);
    forever begin
      if (seen == HOLD_AT) begin
        hold_busy = 1'b1;
        stall     = HOLD_LEN;
      end else begin
        stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      hold_busy = 1'b0;
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %0d, no transaction outstanding", $time, result);
      end else begin
        want = pending_results.pop_front();
        if (result !== want) begin
          mismatches++;
          $display("%0t: result expected %0d, actual %0d", $time, want, result);
        end
      end
      seen++;
    end
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/eau_pkg.sv
sv/eau_arg.sv
sv/eau_sig_lut.sv
sv/eau_post.sv
sv/elementwise_activation_unit_top.sv
tb/tb_elementwise_activation_unit_top.sv
